FILE: design/drs_pkg.sv
// Shared types and constants for the duplicate-rejecting stack.
// Used by drs_cell, drs_ctrl and duplicate_rejecting_stack; depends on nothing.
package drs_pkg;

   localparam int DEPTH   = 16;
   localparam int DATA_W  = 32;
   localparam int CAP_W   = 5;
   localparam int CNT_OUT_W = 5;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int SCAN_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CAP_RESET = 16;
   localparam int REQ_W   = 40;
   localparam int RSP_W   = 40;

   typedef enum logic [1:0] {
      MODE_PUSH = 2'd0,
      MODE_POP  = 2'd1,
      MODE_PEEK = 2'd2,
      MODE_NOP  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_DUP   = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_SCAN = 2'd1,
      S_DONE = 2'd2
   } state_type;

   typedef struct packed {
      logic shift_dn;
      logic shift_up;
   } cell_cmd_type;

endpackage

FILE: design/drs_cell.sv
// One stack cell: holds one entry and one stage of the duplicate search chain.
// Depends on drs_pkg.
module drs_cell (
   input  logic                          clock,
   input  drs_pkg::cell_cmd_type         cmd,
   input  logic [drs_pkg::DATA_W-1:0]    above_entry,
   input  logic [drs_pkg::DATA_W-1:0]    below_entry,
   input  logic                          live,
   input  logic [drs_pkg::DATA_W-1:0]    key_in,
   input  logic                          hit_in,
   output logic [drs_pkg::DATA_W-1:0]    entry,
   output logic [drs_pkg::DATA_W-1:0]    key_out,
   output logic                          hit_out
);

   logic [drs_pkg::DATA_W-1:0] entry_ff, entry_in;
   logic [drs_pkg::DATA_W-1:0] key_ff;
   logic                       hit_ff, hit_in_next;

   always_comb begin
      if (cmd.shift_dn) begin
         entry_in = above_entry;
      end else if (cmd.shift_up) begin
         entry_in = below_entry;
      end else begin
         entry_in = entry_ff;
      end
      hit_in_next = hit_in | (live & (entry_ff == key_in));
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      key_ff   <= key_in;
      hit_ff   <= hit_in_next;
   end

   assign entry   = entry_ff;
   assign key_out = key_ff;
   assign hit_out = hit_ff;

endmodule

FILE: design/drs_ctrl.sv
// Sequencer for the stack: item intake, search timing, fill count and result register.
// Depends on drs_pkg.
module drs_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [drs_pkg::REQ_W-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [drs_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                          csr_we,
   input  logic [drs_pkg::CAP_W-1:0]     csr_wdata,
   input  logic [drs_pkg::DATA_W-1:0]    top_entry,
   input  logic                          scan_hit,
   output logic [drs_pkg::DATA_W-1:0]    item_value,
   output logic [drs_pkg::CNT_W-1:0]     fill,
   output drs_pkg::cell_cmd_type         cmd
);

   drs_pkg::state_type              state_ff, state_in;
   drs_pkg::mode_type               mode_ff;
   logic [drs_pkg::DATA_W-1:0]      value_ff;
   logic [drs_pkg::SCAN_W-1:0]      cnt_ff, cnt_in;
   logic [drs_pkg::CNT_W-1:0]       fill_ff, fill_in;
   logic [drs_pkg::CAP_W-1:0]       cap_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [drs_pkg::RSP_W-1:0]       rsp_data_ff;

   logic                            accept, load, full;
   logic [drs_pkg::CMP_W-1:0]       fill_ext, cap_ext, eff_cap;
   logic [drs_pkg::CNT_W-1:0]       new_fill;
   logic [drs_pkg::DATA_W-1:0]      read_value;
   drs_pkg::status_type             status;
   logic [drs_pkg::CMP_W-1:0]       new_fill_ext;
   logic [drs_pkg::CNT_OUT_W-1:0]   count_out;
   logic [drs_pkg::RSP_W-1:0]       rsp_data_in;

   assign accept   = req_tvalid & req_tready;
   assign load     = (state_ff == drs_pkg::S_DONE) & (~rsp_valid_ff | rsp_tready);
   assign fill_ext = drs_pkg::CMP_W'(fill_ff);
   assign cap_ext  = drs_pkg::CMP_W'(cap_ff);
   assign eff_cap  = (cap_ext > drs_pkg::CMP_W'(drs_pkg::DEPTH)) ?
                     drs_pkg::CMP_W'(drs_pkg::DEPTH) : cap_ext;
   assign full     = fill_ext >= eff_cap;

   // Next state.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         drs_pkg::S_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               if ((drs_pkg::mode_type'(req_tdata[1:0]) == drs_pkg::MODE_PUSH) && !full) begin
                  state_in = drs_pkg::S_SCAN;
               end else begin
                  state_in = drs_pkg::S_DONE;
               end
            end
         end
         drs_pkg::S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == drs_pkg::SCAN_W'(drs_pkg::DEPTH - 1)) begin
               state_in = drs_pkg::S_DONE;
            end
         end
         drs_pkg::S_DONE: begin
            if (load) begin
               state_in = drs_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = drs_pkg::S_IDLE;
         end
      endcase
   end

   // Result and stack commands.
   always_comb begin
      read_value   = '0;
      status       = drs_pkg::ST_OK;
      new_fill     = fill_ff;
      cmd.shift_dn = 1'b0;
      cmd.shift_up = 1'b0;
      case (mode_ff)
         drs_pkg::MODE_PUSH: begin
            if (full) begin
               status = drs_pkg::ST_FULL;
            end else if (scan_hit) begin
               status = drs_pkg::ST_DUP;
            end else begin
               new_fill     = fill_ff + 1'b1;
               cmd.shift_dn = load;
            end
         end
         drs_pkg::MODE_POP: begin
            if (fill_ff == '0) begin
               status = drs_pkg::ST_EMPTY;
            end else begin
               read_value   = top_entry;
               new_fill     = fill_ff - 1'b1;
               cmd.shift_up = load;
            end
         end
         drs_pkg::MODE_PEEK: begin
            if (fill_ff == '0) begin
               status = drs_pkg::ST_EMPTY;
            end else begin
               read_value = top_entry;
            end
         end
         default: begin
            status = drs_pkg::ST_OK;
         end
      endcase
      new_fill_ext = drs_pkg::CMP_W'(new_fill);
      count_out    = new_fill_ext[drs_pkg::CNT_OUT_W-1:0];
      rsp_data_in  = {(new_fill == '0), count_out, status, read_value};
      fill_in      = load ? new_fill : fill_ff;
      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= drs_pkg::S_IDLE;
         cnt_ff       <= '0;
         fill_ff      <= '0;
         cap_ff       <= drs_pkg::CAP_W'(drs_pkg::CAP_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= drs_pkg::mode_type'(req_tdata[1:0]);
         value_ff <= req_tdata[drs_pkg::DATA_W+1:2];
      end
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign req_tready = (state_ff == drs_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign item_value = value_ff;
   assign fill       = fill_ff;

endmodule

FILE: design/duplicate_rejecting_stack.sv
// Top level of the duplicate-rejecting stack: a row of drs_cell plus drs_ctrl.
// Depends on drs_pkg, drs_cell and drs_ctrl.
//
// A bounded last-in-first-out stack of 32-bit values that ignores pushes of a
// value it already holds. Each item on the req_ channel asks for a push, a pop,
// a peek at the top or nothing; each produces exactly one item on the rsp_
// channel with the value read, a status, the entry count and an empty flag.
// The entries sit in a row of cells with the top in the first cell; a push
// shifts the row down and a pop shifts it up. The duplicate search sends the
// pushed value down the row one cell per cycle, so a push that is not full
// gets its result once the search has passed the last cell, and pops, peeks,
// no-ops and full pushes skip the search and go straight to the result.
// One item is in work at a time; the next item is taken once the current
// result is in the output register, even while that result is still waiting.
// A receiver stall holds the result and, once a second result is ready,
// holds the block. Reset empties the stack and sets the capacity to 16; the
// entry contents are not cleared. The capacity is written through csr_we and
// csr_wdata only while the block is idle; the block leaves this to the user.
module duplicate_rejecting_stack (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [drs_pkg::REQ_W-1:0]   req_tdata,  // mode[1:0], push_value[33:2], zero pad
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [drs_pkg::RSP_W-1:0]   rsp_tdata,  // read_value[31:0], status[33:32],
                                                   // entry_count[38:34], empty_flag[39]
   input  logic                        csr_we,
   input  logic [drs_pkg::CAP_W-1:0]   csr_wdata
);

   logic [drs_pkg::DATA_W-1:0] entry   [drs_pkg::DEPTH];
   logic [drs_pkg::DATA_W-1:0] key     [drs_pkg::DEPTH];
   logic                       hit     [drs_pkg::DEPTH];
   logic [drs_pkg::DATA_W-1:0] item_value;
   logic [drs_pkg::CNT_W-1:0]  fill;
   drs_pkg::cell_cmd_type      cmd;

   drs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .top_entry  (entry[0]),
      .scan_hit   (hit[drs_pkg::DEPTH-1]),
      .item_value (item_value),
      .fill       (fill),
      .cmd        (cmd)
   );

   for (genvar i = 0; i < drs_pkg::DEPTH; i++) begin : g_cell
      logic [drs_pkg::DATA_W-1:0] above_entry, below_entry, key_in;
      logic                       hit_in, live;

      assign live = (drs_pkg::CNT_W'(i) < fill);

      if (i == 0) begin : g_first
         assign above_entry = item_value;
         assign key_in      = item_value;
         assign hit_in      = 1'b0;
      end else begin : g_rest
         assign above_entry = entry[i-1];
         assign key_in      = key[i-1];
         assign hit_in      = hit[i-1];
      end

      if (i == drs_pkg::DEPTH - 1) begin : g_last
         assign below_entry = entry[i];
      end else begin : g_mid
         assign below_entry = entry[i+1];
      end

      drs_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .above_entry (above_entry),
         .below_entry (below_entry),
         .live        (live),
         .key_in      (key_in),
         .hit_in      (hit_in),
         .entry       (entry[i]),
         .key_out     (key[i]),
         .hit_out     (hit[i])
      );
   end

endmodule

FILE: tb/sv/tb_duplicate_rejecting_stack.sv
`timescale 1ns / 100ps
// Self-checking testbench for duplicate_rejecting_stack: a directed table, then random phases.
// Depends on drs_pkg and duplicate_rejecting_stack; checked by table rows and a predictor.
module tb_duplicate_rejecting_stack;

   localparam int PLAN_LEN = 27;
   localparam int RANDOM_ITEMS = 2000;
   localparam int STALL_LIMIT = 4000;
   localparam int POOL_SIZE = 24;

   typedef struct packed {
      logic                       empty;
      logic [4:0]                 count;
      drs_pkg::status_type        status;
      logic [drs_pkg::DATA_W-1:0] value;
   } stack_rsp_type;

   typedef enum logic {ROW_ITEM, ROW_CAP} row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      drs_pkg::mode_type   op;
      logic [31:0]         val;
      logic                known;
      logic [31:0]         rd;
      drs_pkg::status_type st;
      logic [4:0]          cnt;
      logic                emp;
   } plan_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [drs_pkg::REQ_W-1:0]  req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [drs_pkg::RSP_W-1:0]  rsp_tdata;
   logic                       csr_we = 1'b0;
   logic [drs_pkg::CAP_W-1:0]  csr_wdata = '0;

   logic              typed_valid = 1'b0;
   stack_rsp_type     typed_rsp = '0;

   logic [31:0]       stk_entries [drs_pkg::DEPTH];
   int                stk_fill;
   logic [4:0]        stk_cap;
   stack_rsp_type     pending_results [$];
   int                mismatch_count = 0;
   int                quiet_cycles = 0;
   int                sent_items = 0;
   int                burst_left = 1;
   int                tick = 0;
   int                stall_style = 0;

   plan_row_type plan [PLAN_LEN] = '{
      '{ROW_ITEM, drs_pkg::MODE_POP,  32'h0000_0000, 1'b1, 32'h0, drs_pkg::ST_EMPTY, 5'd0, 1'b1},
      '{ROW_ITEM, drs_pkg::MODE_PEEK, 32'h0000_0000, 1'b1, 32'h0, drs_pkg::ST_EMPTY, 5'd0, 1'b1},
      '{ROW_ITEM, drs_pkg::MODE_NOP,  32'hFFFF_FFFF, 1'b1, 32'h0, drs_pkg::ST_OK,    5'd0, 1'b1},
      '{ROW_ITEM, drs_pkg::MODE_PUSH, 32'h8000_0000, 1'b1, 32'h0, drs_pkg::ST_OK,    5'd1, 1'b0},
      '{ROW_ITEM, drs_pkg::MODE_PUSH, 32'h7FFF_FFFF, 1'b1, 32'h0, drs_pkg::ST_OK,    5'd2, 1'b0},
      '{ROW_ITEM, drs_pkg::MODE_PUSH, 32'h8000_0000, 1'b1, 32'h0, drs_pkg::ST_DUP,   5'd2, 1'b0},
      '{ROW_ITEM, drs_pkg::MODE_PUSH, 32'hFFFF_FFFF, 1'b1, 32'h0, drs_pkg::ST_OK,    5'd3, 1'b0},
      '{ROW_ITEM, drs_pkg::MODE_PUSH, 32'h0000_0000, 1'b1, 32'h0, drs_pkg::ST_OK,    5'd4, 1'b0},
      '{ROW_ITEM, drs_pkg::MODE_PEEK, 32'h0000_0000, 1'b1, 32'h0, drs_pkg::ST_OK,    5'd4, 1'b0},
      '{ROW_ITEM, drs_pkg::MODE_PUSH, 32'hAAAA_AAAA, 1'b0, 32'h0, drs_pkg::ST_OK,    5'd0, 1'b0},
      '{ROW_ITEM, drs_pkg::MODE_PUSH, 32'h5555_5555, 1'b0, 32'h0, drs_pkg::ST_OK,    5'd0, 1'b0},
      '{ROW_ITEM, drs_pkg::MODE_POP,  32'h0000_0000, 1'b0, 32'h0, drs_pkg::ST_OK,    5'd0, 1'b0},
      '{ROW_ITEM, drs_pkg::MODE_POP,  32'h0000_0000, 1'b0, 32'h0, drs_pkg::ST_OK,    5'd0, 1'b0},
      '{ROW_ITEM, drs_pkg::MODE_PUSH, 32'h5555_5555, 1'b0, 32'h0, drs_pkg::ST_OK,    5'd0, 1'b0},
      '{ROW_CAP,  drs_pkg::MODE_NOP,  32'd0,         1'b0, 32'h0, drs_pkg::ST_OK,    5'd0, 1'b0},
      '{ROW_ITEM, drs_pkg::MODE_PUSH, 32'h1234_5678, 1'b1, 32'h0, drs_pkg::ST_FULL,  5'd5, 1'b0},
      '{ROW_ITEM, drs_pkg::MODE_POP,  32'h0000_0000, 1'b0, 32'h0, drs_pkg::ST_OK,    5'd0, 1'b0},
      '{ROW_CAP,  drs_pkg::MODE_NOP,  32'd31,        1'b0, 32'h0, drs_pkg::ST_OK,    5'd0, 1'b0},
      '{ROW_ITEM, drs_pkg::MODE_PUSH, 32'h7FFF_FFFF, 1'b0, 32'h0, drs_pkg::ST_OK,    5'd0, 1'b0},
      '{ROW_CAP,  drs_pkg::MODE_NOP,  32'd2,         1'b0, 32'h0, drs_pkg::ST_OK,    5'd0, 1'b0},
      '{ROW_ITEM, drs_pkg::MODE_PUSH, 32'h0000_0001, 1'b1, 32'h0, drs_pkg::ST_FULL,  5'd4, 1'b0},
      '{ROW_ITEM, drs_pkg::MODE_PEEK, 32'h0000_0000, 1'b0, 32'h0, drs_pkg::ST_OK,    5'd0, 1'b0},
      '{ROW_ITEM, drs_pkg::MODE_POP,  32'h0000_0000, 1'b0, 32'h0, drs_pkg::ST_OK,    5'd0, 1'b0},
      '{ROW_ITEM, drs_pkg::MODE_POP,  32'h0000_0000, 1'b0, 32'h0, drs_pkg::ST_OK,    5'd0, 1'b0},
      '{ROW_ITEM, drs_pkg::MODE_POP,  32'h0000_0000, 1'b0, 32'h0, drs_pkg::ST_OK,    5'd0, 1'b0},
      '{ROW_ITEM, drs_pkg::MODE_PUSH, 32'h0000_0001, 1'b0, 32'h0, drs_pkg::ST_OK,    5'd0, 1'b0},
      '{ROW_ITEM, drs_pkg::MODE_PUSH, 32'h0000_0002, 1'b1, 32'h0, drs_pkg::ST_FULL,  5'd2, 1'b0}
   };

   duplicate_rejecting_stack dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic stack_rsp_type stack_step(drs_pkg::mode_type op, logic [31:0] val);
      stack_rsp_type r;
      int            lim;
      logic          hit;
      r.value = '0;
      r.status = drs_pkg::ST_OK;
      hit = 1'b0;
      lim = (int'(stk_cap) > drs_pkg::DEPTH) ? drs_pkg::DEPTH : int'(stk_cap);
      case (op)
         drs_pkg::MODE_PUSH: begin
            if (stk_fill >= lim) begin
               r.status = drs_pkg::ST_FULL;
            end else begin
               for (int i = 0; i < stk_fill; i++)
                  if (stk_entries[i] == val) hit = 1'b1;
               if (hit) begin
                  r.status = drs_pkg::ST_DUP;
               end else begin
                  stk_entries[stk_fill] = val;
                  stk_fill++;
               end
            end
         end
         drs_pkg::MODE_POP, drs_pkg::MODE_PEEK: begin
            if (stk_fill == 0) begin
               r.status = drs_pkg::ST_EMPTY;
            end else begin
               r.value = stk_entries[stk_fill - 1];
               if (op == drs_pkg::MODE_POP) stk_fill--;
            end
         end
         default: ;
      endcase
      r.count = stk_fill[4:0];
      r.empty = (stk_fill == 0);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : result_check
      stack_rsp_type predicted;
      stack_rsp_type got;
      stack_rsp_type want;
      if (reset) begin
         stk_fill = 0;
         stk_cap = 5'(drs_pkg::CAP_RESET);
         quiet_cycles = 0;
      end else begin
         if (csr_we) stk_cap = csr_wdata;
         if (req_tvalid && req_tready) begin
            predicted = stack_step(drs_pkg::mode_type'(req_tdata[1:0]), req_tdata[33:2]);
            pending_results.push_back(typed_valid ? typed_rsp : predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_results.size() == 0) begin
               report_mismatch("item with nothing pending", got.value, 32'h0);
            end else begin
               want = pending_results.pop_front();
               if (got.value !== want.value)
                  report_mismatch("read_value", got.value, want.value);
               if (got.status !== want.status)
                  report_mismatch("status", 32'(got.status), 32'(want.status));
               if (got.count !== want.count)
                  report_mismatch("entry_count", 32'(got.count), 32'(want.count));
               if (got.empty !== want.empty)
                  report_mismatch("empty_flag", 32'(got.empty), 32'(want.empty));
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      tick++;
      if (tick % 200 == 0) stall_style = $urandom_range(0, 3);
      case (stall_style)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 1) == 1);
         2: rsp_tready <= ((tick % 29) < 20);
         default: rsp_tready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   task automatic send_item(drs_pkg::mode_type op, logic [31:0] val, logic known,
                            stack_rsp_type rsp);
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, val, op};
      typed_valid <= known;
      typed_rsp <= rsp;
      do @(posedge clock); while (!req_tready);
      sent_items++;
      burst_left--;
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 25)) @(posedge clock);
         burst_left = $urandom_range(1, 50);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_capacity(logic [4:0] cap);
      drain_results();
      csr_we <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      stack_rsp_type     typed;
      drs_pkg::mode_type op;
      logic [31:0]       val;
      logic [31:0]       value_pool [POOL_SIZE];
      logic [4:0]        cap;
      int                phase_len;
      int                push_pct;
      int                pick;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < PLAN_LEN; r++) begin
         if (plan[r].kind == ROW_CAP) begin
            write_capacity(plan[r].val[4:0]);
         end else begin
            typed.value = plan[r].rd;
            typed.status = plan[r].st;
            typed.count = plan[r].cnt;
            typed.empty = plan[r].emp;
            send_item(plan[r].op, plan[r].val, plan[r].known, typed);
         end
      end

      while (sent_items < PLAN_LEN + RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0: cap = 5'd0;
            1: cap = 5'd1;
            2: cap = 5'd16;
            3: cap = 5'd31;
            default: cap = 5'($urandom_range(2, 30));
         endcase
         write_capacity(cap);
         push_pct = $urandom_range(30, 80);
         phase_len = (cap == 5'd0) ? 20 : $urandom_range(60, 200);
         for (int i = 0; i < POOL_SIZE; i++) value_pool[i] = $urandom();
         repeat (phase_len) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
               op = drs_pkg::MODE_NOP;
            else if (pick < push_pct)
               op = drs_pkg::MODE_PUSH;
            else if ($urandom_range(0, 3) == 0)
               op = drs_pkg::MODE_PEEK;
            else
               op = drs_pkg::MODE_POP;
            if ($urandom_range(0, 2) != 0)
               val = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
               val = $urandom();
            send_item(op, val, 1'b0, '0);
         end
      end

      drain_results();
      repeat (drs_pkg::DEPTH + 4) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("items still pending", pending_results.size(), 32'h0);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
